// ===== sv/ftr_pkg.sv =====
// Shared sizes, opcodes and address helpers for the dirty rectangle tracker.
package ftr_pkg;

  localparam int MAX_WIDTH  = 320;
  localparam int MAX_HEIGHT = 200;

  localparam int X_W   = 9;
  localparam int Y_W   = 8;
  localparam int V_W   = 8;
  localparam int OP_W  = 2;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int IDX_W = $clog2(DEPTH);

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_PIXEL = 2'd0,
    OP_EOF   = 2'd1,
    OP_FORCE = 2'd2
  } op_t;

  typedef enum logic {
    REG_ACTIVE_WIDTH  = 1'b0,
    REG_ACTIVE_HEIGHT = 1'b1
  } reg_idx_t;

  function automatic logic [IDX_W-1:0] pix_index(input logic [X_W-1:0] x,
                                                 input logic [Y_W-1:0] y);
    pix_index = IDX_W'(y) * IDX_W'(MAX_WIDTH) + IDX_W'(x);
  endfunction

endpackage

// ===== sv/ftr_if.sv =====
// Valid/ready channel interfaces for pixel items and frame results.
interface ftr_in_if;
  logic                      valid;
  logic                      ready;
  logic [ftr_pkg::OP_W-1:0]  opcode;
  logic [ftr_pkg::X_W-1:0]   pix_x;
  logic [ftr_pkg::Y_W-1:0]   pix_y;
  logic [ftr_pkg::V_W-1:0]   pixel_value;

  modport source (output valid, output opcode, output pix_x, output pix_y,
                  output pixel_value, input ready);
  modport sink   (input valid, input opcode, input pix_x, input pix_y,
                  input pixel_value, output ready);
endinterface

interface ftr_out_if;
  logic                     valid;
  logic                     ready;
  logic                     changed;
  logic [ftr_pkg::X_W-1:0]  rect_x;
  logic [ftr_pkg::Y_W-1:0]  rect_y;
  logic [ftr_pkg::X_W-1:0]  rect_w;
  logic [ftr_pkg::Y_W-1:0]  rect_h;

  modport source (output valid, output changed, output rect_x, output rect_y,
                  output rect_w, output rect_h, input ready);
  modport sink   (input valid, input changed, input rect_x, input rect_y,
                  input rect_w, input rect_h, output ready);
endinterface

// ===== sv/frame_dirty_rect_tracker_unit.sv =====
// Top level of the frame dirty rectangle tracker.
//
// Items enter on in_ch: opcode 0 carries a pixel (pix_x, pix_y, pixel_value),
// opcode 1 closes a frame, opcode 2 forces the next frame to report the whole
// area. Opcode 3 is dropped. One beat is taken per cycle while not stalled.
// A pixel is looked up in the shadow RAM at acceptance, compared and written
// back in the following cycle; a same-address pixel in the next beat takes the
// written value from a one-entry forward register.
// An end-of-frame beat produces one result beat on out_ch; it passes through
// the s1 register and then the output register, and a stall can hold it in s1.
// The output register holds a waiting result while pixels keep flowing; only a
// second end-of-frame behind an untaken result stalls in_ch.ready.
// Reset sets the force flag and an empty box; the shadow RAM is not cleared and
// has no clearing pass. active_width and active_height reset to 320 and 200 and
// are written over the APB port (0 = full size, oversize saturates).
module frame_dirty_rect_tracker_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  ftr_in_if.sink                        in_ch,
  ftr_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ftr_pkg::PADDR_W-1:0]   paddr,
  input  logic [ftr_pkg::PDATA_W-1:0]   pwdata,
  output logic [ftr_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import ftr_pkg::*;

  logic [X_W-1:0] active_width_r;
  logic [Y_W-1:0] active_height_r;
  logic [X_W-1:0] eff_w;
  logic [Y_W-1:0] eff_h;
  logic           cfg_wr;

  logic           s1_valid_r;
  logic [OP_W-1:0] s1_op_r;
  logic           s1_in_area_r;
  logic [X_W-1:0] s1_x_r;
  logic [Y_W-1:0] s1_y_r;
  logic [V_W-1:0] s1_v_r;
  logic [IDX_W-1:0] s1_idx_r;

  logic           fwd_valid_r;
  logic [IDX_W-1:0] fwd_idx_r;
  logic [V_W-1:0] fwd_data_r;

  logic           force_r;
  logic           any_r;
  logic [X_W-1:0] min_x_r, max_x_r;
  logic [Y_W-1:0] min_y_r, max_y_r;

  logic           out_valid_r;
  logic           out_changed_r;
  logic [X_W-1:0] out_x_r, out_w_r;
  logic [Y_W-1:0] out_y_r, out_h_r;

  logic           stall;
  logic           accept;
  logic [IDX_W-1:0] in_idx;
  logic           in_area;
  logic [V_W-1:0] rd_data;
  logic [V_W-1:0] old_v;
  logic           s1_pix;
  logic           s1_eof;
  logic           wr_en;
  logic           pix_diff;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_width_r  <= X_W'(MAX_WIDTH);
      active_height_r <= Y_W'(MAX_HEIGHT);
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[2]))
        REG_ACTIVE_WIDTH:  active_width_r  <= pwdata[X_W-1:0];
        REG_ACTIVE_HEIGHT: active_height_r <= pwdata[Y_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[2]))
      REG_ACTIVE_WIDTH:  prdata = PDATA_W'(active_width_r);
      REG_ACTIVE_HEIGHT: prdata = PDATA_W'(active_height_r);
      default:           prdata = '0;
    endcase
  end

  assign eff_w = (active_width_r == '0 || active_width_r > X_W'(MAX_WIDTH)) ?
                 X_W'(MAX_WIDTH) : active_width_r;
  assign eff_h = (active_height_r == '0 || active_height_r > Y_W'(MAX_HEIGHT)) ?
                 Y_W'(MAX_HEIGHT) : active_height_r;

  assign s1_eof = s1_valid_r && (s1_op_r == OP_EOF);
  assign s1_pix = s1_valid_r && (s1_op_r == OP_PIXEL) && s1_in_area_r;
  assign stall  = s1_eof && out_valid_r && !out_ch.ready;
  assign in_ch.ready = !stall;
  assign accept = in_ch.valid && !stall;

  assign in_idx  = pix_index(in_ch.pix_x, in_ch.pix_y);
  assign in_area = (in_ch.pix_x < eff_w) && (in_ch.pix_y < eff_h);

  ftr_shadow_ram #(
    .DEPTH (DEPTH),
    .AW    (IDX_W),
    .DW    (V_W)
  ) u_shadow (
    .clk     (clk),
    .rd_en   (!stall),
    .rd_addr (in_idx),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s1_idx_r),
    .wr_data (s1_v_r)
  );

  assign old_v    = (fwd_valid_r && fwd_idx_r == s1_idx_r) ? fwd_data_r : rd_data;
  assign wr_en    = s1_pix;
  assign pix_diff = s1_pix && (old_v != s1_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      fwd_valid_r <= wr_en;
      if (!stall) begin
        s1_valid_r <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_idx_r  <= s1_idx_r;
    fwd_data_r <= s1_v_r;
    if (!stall) begin
      s1_op_r      <= in_ch.opcode;
      s1_in_area_r <= in_area;
      s1_x_r       <= in_ch.pix_x;
      s1_y_r       <= in_ch.pix_y;
      s1_v_r       <= in_ch.pixel_value;
      s1_idx_r     <= in_idx;
    end
  end

  // Box and force flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      force_r <= 1'b1;
      any_r   <= 1'b0;
      min_x_r <= X_W'(MAX_WIDTH);
      max_x_r <= '0;
      min_y_r <= Y_W'(MAX_HEIGHT);
      max_y_r <= '0;
    end else if (pix_diff) begin
      any_r <= 1'b1;
      if (!any_r || s1_x_r < min_x_r) min_x_r <= s1_x_r;
      if (!any_r || s1_x_r > max_x_r) max_x_r <= s1_x_r;
      if (!any_r || s1_y_r < min_y_r) min_y_r <= s1_y_r;
      if (!any_r || s1_y_r > max_y_r) max_y_r <= s1_y_r;
    end else if (s1_valid_r && s1_op_r == OP_FORCE) begin
      force_r <= 1'b1;
    end else if (s1_eof && !stall) begin
      force_r <= 1'b0;
      any_r   <= 1'b0;
      min_x_r <= eff_w;
      max_x_r <= '0;
      min_y_r <= eff_h;
      max_y_r <= '0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_eof && !stall) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_eof && !stall) begin
      if (force_r) begin
        out_changed_r <= 1'b1;
        out_x_r <= '0;
        out_y_r <= '0;
        out_w_r <= eff_w;
        out_h_r <= eff_h;
      end else if (any_r) begin
        out_changed_r <= 1'b1;
        out_x_r <= min_x_r;
        out_y_r <= min_y_r;
        out_w_r <= max_x_r - min_x_r + X_W'(1);
        out_h_r <= max_y_r - min_y_r + Y_W'(1);
      end else begin
        out_changed_r <= 1'b0;
        out_x_r <= '0;
        out_y_r <= '0;
        out_w_r <= '0;
        out_h_r <= '0;
      end
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.changed = out_changed_r;
  assign out_ch.rect_x  = out_x_r;
  assign out_ch.rect_y  = out_y_r;
  assign out_ch.rect_w  = out_w_r;
  assign out_ch.rect_h  = out_h_r;

  a_wr_is_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (s1_valid_r && s1_op_r == OP_PIXEL && s1_in_area_r))
    else $error("shadow write without an in-area pixel");

  a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    any_r |-> (min_x_r <= max_x_r && min_y_r <= max_y_r))
    else $error("dirty box corners out of order");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> (out_valid_r && s1_eof))
    else $error("stalled frame end lost");

  a_fwd_follows_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (fwd_valid_r && fwd_idx_r == $past(s1_idx_r)))
    else $error("forward register missed a shadow write");

endmodule

// ===== sv/ftr_shadow_ram.sv =====
// Single-port-write, single-port-read shadow frame RAM with registered read data.
module ftr_shadow_ram #(
  parameter int DEPTH = 64000,
  parameter int AW    = 16,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== tb/dirty_rect_checker.sv =====
// Checker for the dirty rectangle tracker: mirrors its state, predicts and compares frame results.
module dirty_rect_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  ftr_in_if                           in_mon,
  ftr_out_if                          out_mon,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [ftr_pkg::PADDR_W-1:0] paddr,
  input  logic [ftr_pkg::PDATA_W-1:0] pwdata,
  output int                          fail_count,
  output int                          rects_waiting
);
  timeunit 1ns;
  timeprecision 1ps;
  import ftr_pkg::*;

  typedef struct packed {
    logic           changed;
    logic [X_W-1:0] rect_x;
    logic [Y_W-1:0] rect_y;
    logic [X_W-1:0] rect_w;
    logic [Y_W-1:0] rect_h;
  } frame_rect_t;

  frame_rect_t    rect_q[$];
  bit [V_W-1:0]   mirror [DEPTH];
  logic [X_W-1:0] width_reg  = X_W'(MAX_WIDTH);
  logic [Y_W-1:0] height_reg = Y_W'(MAX_HEIGHT);
  logic           refresh_forced = 1'b1;
  logic           box_open = 1'b0;
  logic [X_W-1:0] lo_x, hi_x;
  logic [Y_W-1:0] lo_y, hi_y;

  initial begin
    fail_count = 0;
    rects_waiting = 0;
  end

  function automatic int area_w();
    return (width_reg == 0 || width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
  endfunction

  function automatic int area_h();
    return (height_reg == 0 || height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
  endfunction

  task automatic predict_beat(input logic [OP_W-1:0] op, input logic [X_W-1:0] x,
                              input logic [Y_W-1:0] y, input logic [V_W-1:0] v);
    int          w;
    int          h;
    int          idx;
    frame_rect_t r;
    w = area_w();
    h = area_h();
    case (op)
      OP_PIXEL: begin
        if (x < w && y < h) begin
          idx = int'(y) * MAX_WIDTH + int'(x);
          if (mirror[idx] != v) begin
            mirror[idx] = v;
            if (!box_open) begin
              lo_x = x; hi_x = x; lo_y = y; hi_y = y;
              box_open = 1'b1;
            end else begin
              if (x < lo_x) lo_x = x;
              if (x > hi_x) hi_x = x;
              if (y < lo_y) lo_y = y;
              if (y > hi_y) hi_y = y;
            end
          end
        end
      end
      OP_FORCE: refresh_forced = 1'b1;
      OP_EOF: begin
        r = '0;
        if (refresh_forced) begin
          r.changed = 1'b1;
          r.rect_w  = X_W'(w);
          r.rect_h  = Y_W'(h);
        end else if (box_open) begin
          r.changed = 1'b1;
          r.rect_x  = lo_x;
          r.rect_y  = lo_y;
          r.rect_w  = hi_x - lo_x + 1'b1;
          r.rect_h  = hi_y - lo_y + 1'b1;
        end
        rect_q.push_back(r);
        refresh_forced = 1'b0;
        box_open = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    frame_rect_t want;
    if (!rst_n) begin
      refresh_forced = 1'b1;
      box_open = 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_ACTIVE_WIDTH) width_reg = pwdata[X_W-1:0];
        else height_reg = pwdata[Y_W-1:0];
      end
      if (out_mon.valid && out_mon.ready) begin
        if (rect_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected beat, expected none, actual c=%0d x=%0d y=%0d w=%0d h=%0d",
                   $time, out_mon.changed, out_mon.rect_x, out_mon.rect_y,
                   out_mon.rect_w, out_mon.rect_h);
        end else begin
          want = rect_q.pop_front();
          check_field("changed", want.changed, out_mon.changed);
          check_field("rect_x", want.rect_x, out_mon.rect_x);
          check_field("rect_y", want.rect_y, out_mon.rect_y);
          check_field("rect_w", want.rect_w, out_mon.rect_w);
          check_field("rect_h", want.rect_h, out_mon.rect_h);
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict_beat(in_mon.opcode, in_mon.pix_x, in_mon.pix_y, in_mon.pixel_value);
    end
    rects_waiting = rect_q.size();
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top: drives pixel, frame and register traffic into the tracker and reports the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ftr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 8;
  localparam int HOLD_CYCLES = 400;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic               psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 fail_count;
  int                 rects_waiting;

  ftr_in_if  in_ch();
  ftr_out_if out_ch();

  frame_dirty_rect_tracker_unit u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  dirty_rect_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fail_count    (fail_count),
    .rects_waiting (rects_waiting)
  );

  bit           touched [DEPTH];
  bit [V_W-1:0] stim_pix [DEPTH];
  int           touched_list[$];
  int           span_w = MAX_WIDTH;
  int           span_h = MAX_HEIGHT;
  bit           frame_forced = 1'b1;
  bit           calm = 1'b0;
  bit           hold_rx = 1'b0;
  int           last_idx = -1;
  int           cycles = 0;

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        hold_rx = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 38);
      end
    end
  end

  function automatic bit fits(input int idx);
    return (idx % MAX_WIDTH) < span_w && (idx / MAX_WIDTH) < span_h;
  endfunction

  task automatic offer(input logic [OP_W-1:0] op, input logic [X_W-1:0] x,
                       input logic [Y_W-1:0] y, input logic [V_W-1:0] v);
    int idx;
    if (!calm && $urandom_range(99) < 38) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.pix_x       <= x;
    in_ch.pix_y       <= y;
    in_ch.pixel_value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    case (op)
      OP_PIXEL: begin
        if (x < span_w && y < span_h) begin
          idx = int'(y) * MAX_WIDTH + int'(x);
          if (!touched[idx]) begin
            touched[idx] = 1'b1;
            touched_list.push_back(idx);
          end
          stim_pix[idx] = v;
          last_idx = idx;
        end
      end
      OP_FORCE: frame_forced = 1'b1;
      OP_EOF:   frame_forced = 1'b0;
      default: ;
    endcase
  endtask

  // First visit to an entry only happens in a forced frame, where the rectangle
  // does not hang on the compare.
  task automatic send_pixel();
    int idx;
    int x;
    int y;
    int v;
    int tries;
    bit outside;
    idx = -1;
    v = $urandom_range(255);
    outside = ($urandom_range(99) < 12);
    if (!outside) begin
      if (last_idx >= 0 && fits(last_idx) && $urandom_range(99) < 15) begin
        idx = last_idx;
      end else if (frame_forced) begin
        if ($urandom_range(99) < 20) x = $urandom_range(1) ? span_w - 1 : 0;
        else x = $urandom_range(span_w - 1);
        if ($urandom_range(99) < 20) y = $urandom_range(1) ? span_h - 1 : 0;
        else y = $urandom_range(span_h - 1);
        idx = y * MAX_WIDTH + x;
      end else begin
        for (tries = 0; tries < 6 && idx < 0 && touched_list.size() > 0; tries++) begin
          idx = touched_list[$urandom_range(touched_list.size() - 1)];
          if (!fits(idx)) idx = -1;
        end
      end
      outside = (idx < 0);
    end
    if (outside) begin
      if ($urandom_range(1)) begin
        x = $urandom_range(511, span_w);
        y = $urandom_range(255);
      end else begin
        x = $urandom_range(511);
        y = $urandom_range(255, span_h);
      end
      offer(OP_PIXEL, X_W'(x), Y_W'(y), V_W'(v));
    end else begin
      if (touched[idx] && $urandom_range(99) < 30) v = stim_pix[idx];
      if (!touched[idx] && v == 0) v = $urandom_range(255, 1);
      offer(OP_PIXEL, X_W'(idx % MAX_WIDTH), Y_W'(idx / MAX_WIDTH), V_W'(v));
    end
  endtask

  task automatic run_frames(input int n, input int eof_pct);
    int r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < eof_pct)
        offer(OP_EOF, X_W'($urandom), Y_W'($urandom), V_W'($urandom));
      else if (r < eof_pct + 4)
        offer(OP_FORCE, X_W'($urandom), Y_W'($urandom), V_W'($urandom));
      else if (r < eof_pct + 6)
        offer(OP_UNUSED, X_W'($urandom), Y_W'($urandom), V_W'($urandom));
      else
        send_pixel();
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (rects_waiting != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t which, input int value);
    int field;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(which));
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (which == REG_ACTIVE_WIDTH) begin
      field = value & 'h1FF;
      span_w = (field == 0 || field > MAX_WIDTH) ? MAX_WIDTH : field;
    end else begin
      field = value & 'hFF;
      span_h = (field == 0 || field > MAX_HEIGHT) ? MAX_HEIGHT : field;
    end
  endtask

  task automatic set_area(input int w, input int h);
    drain();
    write_reg(REG_ACTIVE_WIDTH, w);
    write_reg(REG_ACTIVE_HEIGHT, h);
  endtask

  initial begin
    in_ch.valid       <= 1'b0;
    in_ch.opcode      <= OP_PIXEL;
    in_ch.pix_x       <= '0;
    in_ch.pix_y       <= '0;
    in_ch.pixel_value <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // frame after reset is forced: prime the corners, drop outside and unused beats
    offer(OP_PIXEL, 9'd0, 8'd0, 8'hA5);
    offer(OP_PIXEL, 9'd319, 8'd199, 8'h5A);
    offer(OP_PIXEL, 9'd319, 8'd0, 8'hFF);
    offer(OP_PIXEL, 9'd0, 8'd199, 8'h01);
    offer(OP_PIXEL, 9'd511, 8'd255, 8'h11);
    offer(OP_UNUSED, 9'd0, 8'd0, 8'h00);
    offer(OP_EOF, 9'd0, 8'd0, 8'h00);
    // nothing changed
    offer(OP_PIXEL, 9'd0, 8'd0, 8'hA5);
    offer(OP_EOF, 9'd0, 8'd0, 8'h00);
    // opposite corners span the whole area
    offer(OP_PIXEL, 9'd319, 8'd0, 8'h00);
    offer(OP_PIXEL, 9'd0, 8'd199, 8'hFF);
    offer(OP_EOF, 9'd0, 8'd0, 8'h00);
    // single pixel, then the same address again (offer may put idle cycles between)
    offer(OP_PIXEL, 9'd319, 8'd199, 8'h5B);
    offer(OP_PIXEL, 9'd319, 8'd199, 8'h5B);
    offer(OP_EOF, 9'd0, 8'd0, 8'h00);
    // forced frames whatever the box holds
    offer(OP_FORCE, 9'h1FF, 8'hFF, 8'hFF);
    offer(OP_EOF, 9'h1FF, 8'hFF, 8'hFF);
    offer(OP_FORCE, 9'd0, 8'd0, 8'h00);
    offer(OP_PIXEL, 9'd0, 8'd0, 8'h07);
    offer(OP_EOF, 9'd0, 8'd0, 8'h00);
    drain();

    calm = 1'b1;
    run_frames(150, 8);
    calm = 1'b0;

    set_area(0, 0);
    run_frames(140, 6);

    set_area(1, 1);
    run_frames(120, 10);

    set_area(511, 255);
    hold_rx = 1'b1;
    run_frames(150, 25);

    set_area(17, 9);
    run_frames(140, 8);

    set_area($urandom_range(511, 1), $urandom_range(255, 1));
    run_frames(150, 8);

    set_area(320, 200);
    run_frames(140, 5);
    offer(OP_EOF, 9'd0, 8'd0, 8'h00);
    drain();

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ftr_pkg.sv
sv/ftr_if.sv
sv/ftr_shadow_ram.sv
sv/frame_dirty_rect_tracker_unit.sv
tb/dirty_rect_checker.sv
tb/tb.sv
